@@ hdl/sba_pkg.sv @@
`default_nettype none
package sba_pkg;
  localparam int SLOTS = 8;
  localparam int SLOT_W = 3;
  localparam int BITMAP_BITS = 64;
  localparam int BIT_W = 6;
  localparam int CNT_W = 7;
  localparam int ADDR_BITS = 48;
  localparam int SIZE_W = 13;
  localparam int PAGE_SHIFT = 12;
  localparam int DIV_W = 3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SLOT = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  localparam logic [1:0] REG_OBJECT_BYTES = 2'd0;
  localparam logic [1:0] REG_OBJECTS_PER_BUCKET = 2'd1;
  localparam logic [1:0] REG_REGION_BASE = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;

  typedef struct packed {
    logic start;
    logic scan;
    logic div_step;
    logic commit;
  } sba_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
  } sba_stat_t;
endpackage
`default_nettype wire

@@ hdl/slab_bitmap_object_allocator_unit.sv @@
`default_nettype none
// Slab-style allocator of fixed-size objects over eight one-page bucket slots.
// One request is handled at a time. A free is captured, then the slots are
// scanned one per cycle, then a bit-serial divider turns the free offset into
// an object index, then a commit step updates the bitmaps and the result is
// put on the output. An allocate leaves the divider state without dividing.
// The result then waits in the response register until taken, and the input
// is held off until then. Configuration writes are taken at any time outside
// reset and must only happen while the block is idle.
module slab_bitmap_object_allocator_unit
  import sba_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 func,
  input  wire logic [ADDR_BITS-1:0] free_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ADDR_BITS-1:0]      object_address,
  output logic [1:0]                status,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [ADDR_BITS-1:0] cfg_data
);
  logic [SIZE_W-1:0]    object_bytes;
  logic [CNT_W-1:0]     objects_per_bucket;
  logic [ADDR_BITS-1:0] region_base;
  logic [SIZE_W-1:0]    size_eff;
  logic [CNT_W-1:0]     cap_eff;
  sba_cmd_t  cmd;
  sba_stat_t stat;

  // hold off writes during reset so that every accepted write lands
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      object_bytes <= SIZE_W'(64);
      objects_per_bucket <= CNT_W'(64);
      region_base <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBJECT_BYTES: object_bytes <= cfg_data[SIZE_W-1:0];
        REG_OBJECTS_PER_BUCKET: objects_per_bucket <= cfg_data[CNT_W-1:0];
        REG_REGION_BASE: region_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp size to at least one and capacity to 1..BITMAP_BITS
  assign size_eff = (object_bytes == '0) ? SIZE_W'(1) : object_bytes;
  assign cap_eff = (objects_per_bucket == '0) ? CNT_W'(1) :
                   (objects_per_bucket > CNT_W'(BITMAP_BITS)) ? CNT_W'(BITMAP_BITS) :
                   objects_per_bucket;

  sba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(in_valid), .req_ready(in_ready),
    .rsp_valid(out_valid), .rsp_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  sba_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .func(func), .free_address(free_address),
    .size_eff(size_eff), .cap_eff(cap_eff), .region_base(region_base),
    .object_address(object_address), .status(status)
  );
endmodule
`default_nettype wire

@@ hdl/sba_ctrl.sv @@
`default_nettype none
module sba_ctrl
  import sba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  input  wire sba_stat_t stat,
  output sba_cmd_t       cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_DIV  = 5'b00100,
    S_DONE = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = ~rst;
        if (req_valid && !rst) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/sba_datapath.sv @@
`default_nettype none
module sba_datapath
  import sba_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sba_cmd_t              cmd,
  output sba_stat_t                  stat,
  input  wire logic                  func,
  input  wire logic [ADDR_BITS-1:0]  free_address,
  input  wire logic [SIZE_W-1:0]     size_eff,
  input  wire logic [CNT_W-1:0]      cap_eff,
  input  wire logic [ADDR_BITS-1:0]  region_base,
  output logic [ADDR_BITS-1:0]       object_address,
  output logic [1:0]                 status
);
  logic [SLOTS-1:0]             active;
  logic [BITMAP_BITS-1:0]       occ  [SLOTS];
  logic [CNT_W-1:0]             used [SLOTS];
  logic [SLOT_W-1:0]            rank [SLOTS];

  logic                  op_free;
  logic [ADDR_BITS-1:0]  addr;
  logic [SLOT_W-1:0]     idx;
  logic                  found;
  logic [SLOT_W-1:0]     pick;
  logic [SLOT_W-1:0]     best;
  logic                  have_free;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W:0]       nactive;
  // division of offset by object size, restoring, one bit per cycle
  logic [ADDR_BITS-1:0]  rem;
  logic [BIT_W:0]        quo;
  logic [DIV_W-1:0]      div_cnt;

  logic [ADDR_BITS-1:0]  base_i, off_i, base_p, off_p, span;
  logic                  fits;
  logic [ADDR_BITS:0]    trial;
  logic [BITMAP_BITS-1:0] occ_p;
  logic [BIT_W-1:0]      low_bit;
  logic                  low_found;
  logic                  new_slot;

  assign stat.scan_last = (idx == SLOT_W'(SLOTS - 1));
  assign stat.div_done = ~op_free | (div_cnt == '0);

  assign base_i = region_base + (ADDR_BITS'(idx) << PAGE_SHIFT);
  assign off_i = addr - base_i;
  assign span = ADDR_BITS'((CNT_W+SIZE_W)'(cap_eff) * (CNT_W+SIZE_W)'(size_eff));
  assign fits = op_free ? (off_i < span) : (used[idx] < cap_eff);
  assign new_slot = ~op_free & ~found;
  assign base_p = region_base + (ADDR_BITS'(pick) << PAGE_SHIFT);
  assign off_p = addr - base_p;
  assign occ_p = new_slot ? '0 : occ[pick];
  assign trial = {1'b0, rem} - ((ADDR_BITS+1)'(size_eff) << div_cnt);

  always_comb begin
    low_bit = '0;
    low_found = 1'b0;
    for (int b = 0; b < BITMAP_BITS; b++) begin
      if (!low_found && !occ_p[b]) begin
        low_bit = BIT_W'(b);
        low_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_free <= func != FUNC_ALLOC;
      addr <= free_address;
      idx <= '0;
      found <= 1'b0;
      have_free <= 1'b0;
      nactive <= '0;
      div_cnt <= DIV_W'(BIT_W + 1);
      quo <= '0;
    end
    if (cmd.scan) begin
      idx <= idx + 1'b1;
      if (active[idx]) begin
        nactive <= nactive + 1'b1;
        if (fits && (!found || rank[idx] < best)) begin
          found <= 1'b1;
          pick <= idx;
          best <= rank[idx];
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        if (!op_free) begin
          free_slot <= idx;
        end
      end
      if (stat.scan_last && !op_free && !found && !(fits && active[idx])) begin
        pick <= have_free ? free_slot : idx;
      end
    end
    if (cmd.div_step) begin
      if (div_cnt == DIV_W'(BIT_W + 1)) rem <= off_p;
      else if (!trial[ADDR_BITS]) begin
        rem <= trial[ADDR_BITS-1:0];
        quo[div_cnt] <= 1'b1;
      end
      if (div_cnt == DIV_W'(BIT_W + 1)) div_cnt <= DIV_W'(BIT_W);
      else if (div_cnt != '0) div_cnt <= div_cnt - 1'b1;
    end
  end

  // quotient bits are produced for div_cnt BIT_W..0; last step writes bit 0
  logic [ADDR_BITS-1:0] rem_fin;
  logic [BIT_W:0] quo_fin;
  always_comb begin
    rem_fin = rem;
    quo_fin = quo;
    if (op_free && div_cnt == '0 && !trial[ADDR_BITS]) begin
      rem_fin = trial[ADDR_BITS-1:0];
      quo_fin[0] = 1'b1;
    end
  end

  logic no_slot;
  assign no_slot = new_slot & (nactive == (SLOT_W + 1)'(SLOTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= {{SLOTS-1{1'b0}}, 1'b1};
      for (int s = 0; s < SLOTS; s++) begin
        occ[s] <= '0;
        used[s] <= '0;
        rank[s] <= '0;
      end
    end else if (cmd.commit) begin
      object_address <= '0;
      status <= ST_OK;
      if (!op_free) begin
        if (no_slot) begin
          status <= ST_NO_SLOT;
        end else begin
          if (new_slot) begin
            for (int s = 0; s < SLOTS; s++)
              if (active[s]) rank[s] <= rank[s] + 1'b1;
            active[pick] <= 1'b1;
            rank[pick] <= '0;
            used[pick] <= 7'd1;
          end else begin
            used[pick] <= used[pick] + 1'b1;
          end
          occ[pick] <= occ_p | (BITMAP_BITS'(1) << low_bit);
          object_address <= base_p +
                            ADDR_BITS'((BIT_W+SIZE_W)'(low_bit) * (BIT_W+SIZE_W)'(size_eff));
        end
      end else if (!found || rem_fin != '0 || quo_fin[BIT_W] || !occ[pick][quo_fin[BIT_W-1:0]]) begin
        status <= ST_BAD_FREE;
      end else begin
        occ[pick][quo_fin[BIT_W-1:0]] <= 1'b0;
        used[pick] <= used[pick] - 1'b1;
        if (used[pick] == 7'd1 && nactive > 1) begin
          active[pick] <= 1'b0;
          rank[pick] <= '0;
          for (int s = 0; s < SLOTS; s++)
            if (active[s] && rank[s] > rank[pick]) rank[s] <= rank[s] - 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
